### rtl/icc_pkg.sv
// Shared types and constants for the identifier case converter.
// Used by icc_encoder and identifier_case_converter; no dependencies.
package icc_pkg;

	// Case mode register codes; codes 5 to 7 fall back to dash case
	localparam logic [2:0] MODE_DASH   = 3'd0;
	localparam logic [2:0] MODE_PASCAL = 3'd1;
	localparam logic [2:0] MODE_CAMEL  = 3'd2;
	localparam logic [2:0] MODE_SNAKE  = 3'd3;
	localparam logic [2:0] MODE_SCREAM = 3'd4;

	// Joining characters
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_USCORE = 8'h5F;

	// Bit that separates upper from lower case letters in ASCII
	localparam logic [7:0] CASE_BIT = 8'h20;

	// Configuration port
	localparam int unsigned PADDR_W   = 3;
	localparam int unsigned PDATA_W   = 32;
	localparam int unsigned MODE_W    = 3;

	// Result queue
	localparam int unsigned QDEPTH    = 4;
	localparam int unsigned QPTR_W    = $clog2(QDEPTH);
	localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

	// One output word
	typedef struct packed {
		logic [7:0] ch;
		logic       ch_valid;
		logic       last;
	} res_word_t;

	// What the encoder makes of one input byte
	typedef struct packed {
		logic [1:0] n;
		res_word_t  w0;
		res_word_t  w1;
	} enc_res_t;

endpackage

### rtl/identifier_case_converter.sv
// Identifier case converter, top level: config register, input register,
// encoder and result queue. Depends on icc_pkg and icc_encoder.
//
// Usage: bytes of an identifier enter on the input channel (in_valid,
// in_ready, char_in, last_in); last_in marks the final byte. Output words
// leave on the output channel (out_valid, out_ready, char_out, char_valid,
// last_out), one word per cycle while out_ready is high. A byte gives no
// word, one word, or a joiner followed by a letter; a final byte that gives
// nothing yields a bare end word with char_valid low and last_out high.
// A byte taken is held in the input register and encoded from there; its
// words go into the result queue, whose head drives the output channel.
// Throughput: one byte per cycle while each byte gives at most one word and
// out_ready is high; when every byte gives two words, the byte rate is set
// by the single output word per cycle of the four-entry queue. The input
// register holds a byte until the queue has room for two words, so a stalled
// receiver fills the queue until under two entries are free, then in_ready
// goes low. case_mode is written over APB at addresses 0 to 3 (paddr[2] low)
// only while idle; the user must keep to that, the block does not enforce
// it. Reset clears case_mode to dash case, empties the queue and the input
// register, and puts the word state at the start of an identifier.
module identifier_case_converter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [icc_pkg::PADDR_W-1:0]   paddr,
	input  logic [icc_pkg::PDATA_W-1:0]   pwdata,
	output logic [icc_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    char_in,
	input  logic                          last_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    char_out,
	output logic                          char_valid,
	output logic                          last_out
);
	import icc_pkg::*;

	logic [MODE_W-1:0] mode_q;
	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              last_s1;
	logic              room, fire, pop;
	enc_res_t          enc;
	res_word_t         q_mem [QDEPTH];
	logic [QPTR_W-1:0] head_q, tail_q;
	logic [QCNT_W-1:0] count_q;
	res_word_t         head_w;

	// Configuration register
	assign pready = 1'b1;
	assign prdata = paddr[2] ? '0 : {{(PDATA_W-MODE_W){1'b0}}, mode_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_DASH;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			mode_q <= pwdata[MODE_W-1:0];
		end
	end

	// Input register
	assign room     = count_q <= QCNT_W'(QDEPTH - 2);
	assign fire     = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_in;
			last_s1 <= last_in;
		end
	end

	icc_encoder u_enc (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.case_mode (mode_q),
		.char_in   (char_s1),
		.last_in   (last_s1),
		.res       (enc)
	);

	// Result queue: up to two words pushed, one popped per cycle
	assign pop       = out_valid && out_ready;
	assign out_valid = count_q != '0;
	assign head_w    = q_mem[head_q];
	assign char_out  = head_w.ch;
	assign char_valid = head_w.ch_valid;
	assign last_out  = head_w.last;

	always_ff @(posedge clk) begin
		if (fire && enc.n != 2'd0) begin
			q_mem[tail_q] <= enc.w0;
			if (enc.n == 2'd2) begin
				q_mem[tail_q + QPTR_W'(1)] <= enc.w1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + QPTR_W'(1);
			end
			if (fire) begin
				tail_q <= tail_q + QPTR_W'(enc.n);
			end
			count_q <= count_q + (fire ? QCNT_W'(enc.n) : '0) - QCNT_W'(pop);
		end
	end

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("result queue count above depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> count_q <= QCNT_W'(QDEPTH - 2))
		else $error("byte encoded without room for two words");

	a_last_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && last_s1) |-> (enc.n != 2'd0 && (enc.n == 2'd2 ? enc.w1.last : enc.w0.last)))
		else $error("final byte produced no end-marked word");

	a_pop_moves_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> head_q == $past(head_q) + QPTR_W'(1))
		else $error("queue head did not advance on pop");

endmodule

### rtl/icc_encoder.sv
// Word splitter and case encoder: holds the per-identifier word state and
// turns one byte into up to two output words. Depends on icc_pkg.
module icc_encoder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  logic [icc_pkg::MODE_W-1:0]   case_mode,
	input  logic [7:0]                   char_in,
	input  logic                         last_in,
	output icc_pkg::enc_res_t            res
);
	import icc_pkg::*;

	logic at_start_q, word_open_q, any_word_q, prev_upper_q;
	logic [MODE_W-1:0] mode;
	logic is_up, is_lo, is_dig, is_sep, drop, alnum, starts, joiner;
	logic cap;
	logic [7:0] ch, join_ch;
	res_word_t w_ch, w_join;

	// Classify the byte
	always_comb begin
		mode   = (case_mode > MODE_SCREAM) ? MODE_DASH : case_mode;
		is_up  = (char_in >= 8'h41) && (char_in <= 8'h5A);
		is_lo  = (char_in >= 8'h61) && (char_in <= 8'h7A);
		is_dig = (char_in >= 8'h30) && (char_in <= 8'h39);
		is_sep = (char_in == CH_DASH) || (char_in == CH_USCORE) || (char_in == 8'h20) ||
			((char_in >= 8'h09) && (char_in <= 8'h0D));
		drop   = at_start_q && is_dig;
		alnum  = !drop && (is_up || is_lo || is_dig);
		starts = is_up ? (!word_open_q || !prev_upper_q) : !word_open_q;
	end

	// Pick the joiner and the letter's case
	always_comb begin
		joiner  = alnum && starts && any_word_q &&
			((mode == MODE_DASH) || (mode == MODE_SNAKE) || (mode == MODE_SCREAM));
		join_ch = (mode == MODE_DASH) ? CH_DASH : CH_USCORE;
		if (starts)
			cap = (mode == MODE_PASCAL) || (mode == MODE_SCREAM) ||
				((mode == MODE_CAMEL) && any_word_q);
		else
			cap = (mode == MODE_SCREAM);
		if (cap && is_lo)
			ch = char_in & ~CASE_BIT;
		else if (!cap && is_up)
			ch = char_in | CASE_BIT;
		else
			ch = char_in;
	end

	// Assemble the result words; the end mark goes on the final one
	always_comb begin
		w_join = '{ch: join_ch, ch_valid: 1'b1, last: 1'b0};
		w_ch   = '{ch: ch, ch_valid: 1'b1, last: last_in};
		res    = '0;
		if (joiner) begin
			res.n  = 2'd2;
			res.w0 = w_join;
			res.w1 = w_ch;
		end else if (alnum) begin
			res.n  = 2'd1;
			res.w0 = w_ch;
		end else if (last_in) begin
			res.n  = 2'd1;
			res.w0 = '{ch: 8'h00, ch_valid: 1'b0, last: 1'b1};
		end
	end

	// Word state, cleared at the end of each identifier
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q   <= 1'b1;
			word_open_q  <= 1'b0;
			any_word_q   <= 1'b0;
			prev_upper_q <= 1'b0;
		end else if (fire) begin
			if (last_in) begin
				at_start_q   <= 1'b1;
				word_open_q  <= 1'b0;
				any_word_q   <= 1'b0;
				prev_upper_q <= 1'b0;
			end else begin
				at_start_q <= 1'b0;
				if (drop) begin
					// digit at position 0: only at_start_q clears
				end else if (is_sep) begin
					word_open_q  <= 1'b0;
					prev_upper_q <= 1'b0;
				end else if (alnum) begin
					prev_upper_q <= is_up;
					if (starts) begin
						word_open_q <= 1'b1;
						any_word_q  <= 1'b1;
					end
				end
			end
		end
	end

endmodule
